@@ sv/assert_macros.svh @@
// Assertion macros shared by the SHA-256 hasher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SBSH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbsh assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SBSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbsh assertion failed");

`endif

@@ sv/sbsh_pkg.sv @@
// Types, constants and round tables for the SHA-256 byte stream hasher.
package sbsh_pkg;

  localparam int unsigned BLK_W = 55;  // count of completed 512-bit blocks

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } sbsh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sbsh_out_t;

  // Control from the sequencer to the compression core.
  typedef struct packed {
    logic        push;    // shift one message word into the window
    logic [31:0] word;
    logic        start;   // begin 64 rounds on the buffered block
    logic        reinit;  // load the initial hash values
  } sbsh_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;  // chaining words update at this edge
  } sbsh_stat_t;

  function automatic logic [31:0] sbsh_iv(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sbsh_k(input logic [5:0] t);
    logic [31:0] v;
    unique case (t)
      6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7; 6'd63: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

endpackage

@@ sv/sha256_byte_stream_hasher_top.sv @@
// SHA-256 byte stream hasher: byte packing, padding sequencer and digest output.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_ready    sbsh_in_t  {req_type, data_byte}
//   out_     out  out_valid / out_ready  sbsh_out_t {digest_word, word_index, last_word}
//
// An append beat adds one byte; the 64th byte of a block also starts the
// 64 serial rounds of the shared round unit plus load and chaining update.
// A finish beat feeds padding bytes one per cycle (up to 64, twice when the length
// spills into a second block) with one or two compressions, then shows eight words.
// in_ready is high only while idle; the digest words hold until out_ready takes them.
// Reset is synchronous: chaining words return to the initial values, counts to zero.
`include "assert_macros.svh"

module sha256_byte_stream_hasher_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sbsh_pkg::sbsh_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sbsh_pkg::sbsh_out_t   out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [5:0]               fill_r, fill_nxt;
  logic [23:0]              part_r, part_nxt;
  logic [sbsh_pkg::BLK_W-1:0] blocks_r, blocks_nxt;
  logic [63:0]              len_r, len_nxt;
  logic                     pad_mode_r, pad_mode_nxt;
  logic                     pad_first_r, pad_first_nxt;
  logic                     len_ok_r, len_ok_nxt;
  logic                     final_r, final_nxt;
  logic                     start_r, start_nxt;
  logic [2:0]               widx_r, widx_nxt;

  logic                     feed_en;
  logic [7:0]               feed_byte;
  logic                     push;
  logic                     reinit;

  sbsh_pkg::sbsh_ctrl_t     ctrl;
  sbsh_pkg::sbsh_stat_t     stat;
  logic [7:0][31:0]         digest;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    part_nxt      = part_r;
    blocks_nxt    = blocks_r;
    len_nxt       = len_r;
    pad_mode_nxt  = pad_mode_r;
    pad_first_nxt = pad_first_r;
    len_ok_nxt    = len_ok_r;
    final_nxt     = final_r;
    start_nxt     = 1'b0;
    widx_nxt      = widx_r;
    feed_en       = 1'b0;
    feed_byte     = '0;
    push          = 1'b0;
    reinit        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == sbsh_pkg::REQ_FINISH) begin
            len_nxt       = {blocks_r, fill_r, 3'b000};
            pad_mode_nxt  = 1'b1;
            pad_first_nxt = 1'b1;
            len_ok_nxt    = 1'b0;
            state_nxt     = ST_PAD;
          end else begin
            feed_en   = 1'b1;
            feed_byte = in_data.data_byte;
          end
        end
      end
      ST_PAD: begin
        feed_en       = 1'b1;
        pad_first_nxt = 1'b0;
        if (pad_first_r) begin
          feed_byte = 8'h80;
          if (fill_r < 6'd56) len_ok_nxt = 1'b1;
        end else if (len_ok_r && fill_r[5:3] == 3'b111) begin
          // length field, most significant byte first
          feed_byte = len_r[63:56];
          len_nxt   = {len_r[55:0], 8'h00};
        end
      end
      ST_COMP: begin
        if (stat.done) begin
          if (final_r) begin
            widx_nxt  = '0;
            state_nxt = ST_OUT;
          end else if (pad_mode_r) begin
            state_nxt = ST_PAD;
          end else begin
            blocks_nxt = blocks_r + 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          widx_nxt = widx_r + 3'd1;
          if (widx_r == 3'd7) begin
            reinit       = 1'b1;
            blocks_nxt   = '0;
            fill_nxt     = '0;
            pad_mode_nxt = 1'b0;
            len_ok_nxt   = 1'b0;
            final_nxt    = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
    endcase

    // Pack bytes big-endian into words; a full block starts the rounds.
    if (feed_en) begin
      part_nxt = {part_r[15:0], feed_byte};
      push     = (fill_r[1:0] == 2'b11);
      fill_nxt = fill_r + 6'd1;
      if (fill_r == 6'd63) begin
        start_nxt = 1'b1;
        state_nxt = ST_COMP;
        if (pad_mode_r) begin
          final_nxt  = len_ok_r && !pad_first_r;
          len_ok_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      blocks_r    <= '0;
      pad_mode_r  <= 1'b0;
      pad_first_r <= 1'b0;
      len_ok_r    <= 1'b0;
      final_r     <= 1'b0;
      start_r     <= 1'b0;
      widx_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      blocks_r    <= blocks_nxt;
      pad_mode_r  <= pad_mode_nxt;
      pad_first_r <= pad_first_nxt;
      len_ok_r    <= len_ok_nxt;
      final_r     <= final_nxt;
      start_r     <= start_nxt;
      widx_r      <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    part_r <= part_nxt;
    len_r  <= len_nxt;
  end

  assign ctrl.push   = push;
  assign ctrl.word   = {part_r, feed_byte};
  assign ctrl.start  = start_r;
  assign ctrl.reinit = reinit;

  sbsh_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .stat   (stat),
    .digest (digest)
  );

  assign out_data.digest_word = digest[widx_r];
  assign out_data.word_index  = widx_r;
  assign out_data.last_word   = (widx_r == 3'd7);

  `SBSH_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `SBSH_ASSERT_NEXT(a_digest_first, clk, rst_n, state_r == ST_COMP && stat.done && final_r,
                    out_valid && out_data.word_index == 3'd0)
  `SBSH_ASSERT_NEXT(a_end_clean, clk, rst_n, out_valid && out_ready && out_data.last_word,
                    in_ready && fill_r == 6'd0 && blocks_r == '0)

endmodule

@@ sv/sbsh_core.sv @@
// SHA-256 compression core: message window, one round unit, chaining words.
`include "assert_macros.svh"

module sbsh_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sbsh_pkg::sbsh_ctrl_t     ctrl,
  output sbsh_pkg::sbsh_stat_t     stat,
  output logic [7:0][31:0]         digest
);

  logic [31:0] win_r  [16];  // block words, then rolling message schedule
  logic [31:0] work_r [8];   // a..h
  logic [31:0] chain_r[8];
  logic [5:0]  round_r;
  logic        busy_r;
  logic        add_r;

  logic [31:0] new_w;
  logic [31:0] t1;
  logic [31:0] t2;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction

  always_comb begin
    logic [31:0] s0, s1, big0, big1, ch, maj;
    s0   = ror(win_r[1], 7) ^ ror(win_r[1], 18) ^ (win_r[1] >> 3);
    s1   = ror(win_r[14], 17) ^ ror(win_r[14], 19) ^ (win_r[14] >> 10);
    new_w = win_r[0] + s0 + win_r[9] + s1;
    big1 = ror(work_r[4], 6) ^ ror(work_r[4], 11) ^ ror(work_r[4], 25);
    ch   = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    t1   = work_r[7] + big1 + ch + sbsh_pkg::sbsh_k(round_r) + win_r[0];
    big0 = ror(work_r[0], 2) ^ ror(work_r[0], 13) ^ ror(work_r[0], 22);
    maj  = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    t2   = big0 + maj;
  end

  // Control and chaining words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      add_r   <= 1'b0;
      round_r <= '0;
      for (int j = 0; j < 8; j++) chain_r[j] <= sbsh_pkg::sbsh_iv(3'(j));
    end else begin
      if (ctrl.start) begin
        busy_r  <= 1'b1;
        round_r <= '0;
      end else if (busy_r) begin
        round_r <= round_r + 6'd1;
        if (round_r == 6'd63) begin
          busy_r <= 1'b0;
          add_r  <= 1'b1;
        end
      end else if (add_r) begin
        add_r <= 1'b0;
        for (int j = 0; j < 8; j++) chain_r[j] <= chain_r[j] + work_r[j];
      end
      if (ctrl.reinit) begin
        for (int j = 0; j < 8; j++) chain_r[j] <= sbsh_pkg::sbsh_iv(3'(j));
      end
    end
  end

  // Window and working variables.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      for (int j = 0; j < 8; j++) work_r[j] <= chain_r[j];
    end else if (busy_r) begin
      work_r[7] <= work_r[6];
      work_r[6] <= work_r[5];
      work_r[5] <= work_r[4];
      work_r[4] <= work_r[3] + t1;
      work_r[3] <= work_r[2];
      work_r[2] <= work_r[1];
      work_r[1] <= work_r[0];
      work_r[0] <= t1 + t2;
    end
    if (busy_r || ctrl.push) begin
      for (int j = 0; j < 15; j++) win_r[j] <= win_r[j + 1];
      win_r[15] <= busy_r ? new_w : ctrl.word;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = add_r;

  always_comb begin
    for (int j = 0; j < 8; j++) digest[j] = chain_r[j];
  end

  `SBSH_ASSERT_NOW(a_start_idle, clk, rst_n, ctrl.start, !busy_r && !add_r)
  `SBSH_ASSERT_NOW(a_push_idle, clk, rst_n, ctrl.push, !busy_r)
  `SBSH_ASSERT_NEXT(a_last_round, clk, rst_n, busy_r && round_r == 6'd63 && !ctrl.start,
                    add_r && !busy_r)

endmodule
